// File: rtl/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

  localparam int ADDR_W    = 48;
  localparam int BASE_W    = 36;
  localparam int COUNT_W   = 13;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_MARK,
    CMD_QUERY
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NO_FREE,
    ST_NOT_IN_RANGE,
    ST_MISALIGNED,
    ST_ALREADY_FREE
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_R0_BASE,
    CFG_R0_COUNT,
    CFG_R1_BASE,
    CFG_R1_COUNT
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SINGLE_RD,
    S_SINGLE_UPD,
    S_SCAN,
    S_ALLOC_WR,
    S_ALLOC_FAIL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic single_rd;
    logic single_upd;
    logic scan_init;
    logic scan_rd;
    logic alloc_wr;
    logic alloc_fail;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic req_alloc;
    logic hit;
    logic scan_issued;
    logic eval_pending;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/bpa_ctrl.sv
`default_nettype none
module bpa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bpa_pkg::stat_t stat,
  output bpa_pkg::ctrl_t ctrl
);
  import bpa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        ctrl.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          if (stat.req_alloc) begin
            ctrl.scan_init = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_SINGLE_RD;
          end
        end
      end
      S_SINGLE_RD: begin
        ctrl.single_rd = 1'b1;
        state_nxt      = S_SINGLE_UPD;
      end
      S_SINGLE_UPD: begin
        if (stat.out_free) begin
          ctrl.single_upd = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_nxt = S_ALLOC_WR;
        end else if (!stat.scan_issued) begin
          ctrl.scan_rd = 1'b1;
        end else if (!stat.eval_pending) begin
          state_nxt = S_ALLOC_FAIL;
        end
      end
      S_ALLOC_WR: begin
        if (stat.out_free) begin
          ctrl.alloc_wr = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ALLOC_FAIL: begin
        if (stat.out_free) begin
          ctrl.alloc_fail = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/bpa_datapath.sv
`default_nettype none
module bpa_datapath #(
  parameter int PAGE_BYTES      = 4096,
  parameter int BITS_PER_WORD   = 32,
  parameter int PAGES_PER_RANGE = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [bpa_pkg::CMD_W-1:0]      in_command,
  input  logic [bpa_pkg::ADDR_W-1:0]     in_page_address,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [bpa_pkg::ADDR_W-1:0]     out_result_address,
  output logic [bpa_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_page_used,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpa_pkg::BASE_W-1:0]     cfg_data,
  input  bpa_pkg::ctrl_t                 ctrl,
  output bpa_pkg::stat_t                 stat
);
  import bpa_pkg::*;

  localparam int PBL   = $clog2(PAGE_BYTES);
  localparam int BWL   = $clog2(BITS_PER_WORD);
  localparam int WPR   = (PAGES_PER_RANGE + BITS_PER_WORD - 1) / BITS_PER_WORD;
  localparam int DEPTH = 2 * WPR;
  localparam int AW    = $clog2(DEPTH);
  localparam int LWW   = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int OFFW  = $clog2(WPR * BITS_PER_WORD);
  localparam int LIMW  = OFFW + 1;
  localparam int PNW   = ADDR_W - PBL;
  localparam int MW    = ADDR_W + 2;

  localparam logic [MW-1:0]            PN_LIMIT  = MW'(1) << PNW;
  localparam logic [LIMW-1:0]          PAGES_LIM = LIMW'(PAGES_PER_RANGE);
  localparam logic [BITS_PER_WORD-1:0] ONE_W     = BITS_PER_WORD'(1);

  typedef logic [BITS_PER_WORD-1:0] word_t;

  function automatic logic [AW-1:0] waddr(input logic rng, input logic [LWW-1:0] lw);
    logic [AW-1:0] a;
    a = rng ? (AW'(WPR) + AW'(lw)) : AW'(lw);
    return a;
  endfunction

  // configuration
  logic [BASE_W-1:0]  base_r  [2];
  logic [COUNT_W-1:0] count_r [2];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r[0]  <= '0;
      base_r[1]  <= '0;
      count_r[0] <= '0;
      count_r[1] <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_R0_BASE:  base_r[0]  <= cfg_data;
        CFG_R0_COUNT: count_r[0] <= cfg_data[COUNT_W-1:0];
        CFG_R1_BASE:  base_r[1]  <= cfg_data;
        CFG_R1_COUNT: count_r[1] <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped counts and allocatable limits per range
  logic [LIMW-1:0] neff    [2];
  logic [LIMW-1:0] lim_nxt [2];
  logic [LIMW-1:0] lim_r   [2];
  logic            zero_r  [2];
  logic [MW-1:0]   head    [2];

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      neff[r] = (int'(count_r[r]) > PAGES_PER_RANGE) ? PAGES_LIM : LIMW'(count_r[r]);
      head[r] = PN_LIMIT - MW'(base_r[r]);
      if (MW'(base_r[r]) >= PN_LIMIT) begin
        lim_nxt[r] = '0;
      end else if (head[r] < MW'(neff[r])) begin
        lim_nxt[r] = LIMW'(head[r]);
      end else begin
        lim_nxt[r] = neff[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 2; r++) begin
      lim_r[r]  <= lim_nxt[r];
      zero_r[r] <= (base_r[r] == '0);
    end
  end

  // request capture
  cmd_t              cap_cmd_r;
  logic [ADDR_W-1:0] cap_addr_r;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cap_cmd_r  <= cmd_t'(in_command);
      cap_addr_r <= in_page_address;
    end
  end

  // single page decode
  logic [PNW-1:0]  pn;
  logic [MW-1:0]   diff [2];
  logic            inr  [2];
  logic [OFFW-1:0] dec_off;
  logic            dec_sel;
  logic [AW-1:0]   dec_widx;
  logic            dec_mis;

  always_comb begin
    pn = cap_addr_r[ADDR_W-1:PBL];
    for (int r = 0; r < 2; r++) begin
      diff[r] = MW'(pn) - MW'(base_r[r]);
      inr[r]  = (MW'(pn) >= MW'(base_r[r])) && (diff[r] < MW'(neff[r]));
    end
    // range zero wins on overlap
    dec_sel  = !inr[0];
    dec_off  = inr[0] ? OFFW'(diff[0]) : OFFW'(diff[1]);
    dec_widx = waddr(dec_sel, LWW'(dec_off >> BWL));
    dec_mis  = (cap_cmd_r == CMD_FREE) && (cap_addr_r[PBL-1:0] != '0);
  end

  logic           d_found_r;
  logic           d_mis_r;
  logic           d_pnzero_r;
  logic [BWL-1:0] d_bit_r;
  logic [AW-1:0]  d_widx_r;

  always_ff @(posedge clk) begin
    if (ctrl.single_rd) begin
      d_found_r  <= inr[0] || inr[1];
      d_mis_r    <= dec_mis;
      d_pnzero_r <= (pn == '0);
      d_bit_r    <= dec_off[BWL-1:0];
      d_widx_r   <= dec_widx;
    end
  end

  // bitmap memory
  word_t         mem [DEPTH];
  word_t         mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  word_t         mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  // clearing pass after reset
  logic [AW-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (ctrl.clear_wr) begin
      clr_idx_r <= clr_idx_r + AW'(1);
    end
  end

  // single page update
  logic [BWL-1:0] d_pos;
  word_t          d_mask;
  logic           su_used;
  logic           su_used_out;
  logic           su_write;
  word_t          su_word;
  status_t        su_status;

  always_comb begin
    d_pos       = ~d_bit_r;
    d_mask      = ONE_W << d_pos;
    su_used     = mem_q[d_pos] || d_pnzero_r;
    su_used_out = 1'b0;
    su_write    = 1'b0;
    su_word     = mem_q;
    su_status   = ST_OK;
    if (d_mis_r) begin
      su_status = ST_MISALIGNED;
    end else if (!d_found_r) begin
      su_status = ST_NOT_IN_RANGE;
    end else begin
      su_used_out = su_used;
      case (cap_cmd_r)
        CMD_FREE: begin
          if (!su_used) begin
            su_status = ST_ALREADY_FREE;
          end else begin
            su_write = 1'b1;
            su_word  = mem_q & ~d_mask;
          end
        end
        CMD_MARK: begin
          su_write = 1'b1;
          su_word  = mem_q | d_mask;
        end
        default: ;
      endcase
    end
  end

  // allocate scan: read one word a cycle, evaluate the previous one
  logic           scan_range_r;
  logic [LWW-1:0] scan_lw_r;
  logic           scan_done_r;
  logic           ev_v_r;
  logic           ev_range_r;
  logic [LWW-1:0] ev_lw_r;
  logic           hit_r;
  logic           hit_range_r;
  logic [LWW-1:0] hit_lw_r;
  logic [BWL-1:0] hit_j_r;
  word_t          hit_word_r;

  logic [OFFW-1:0]          ev_wo;
  logic [LIMW-1:0]          ev_lim;
  logic [LIMW-1:0]          ev_rem;
  logic                     ev_zx;
  logic [BITS_PER_WORD-1:0] ev_free;
  logic [BWL-1:0]           ev_pick;
  logic                     ev_hit;
  logic                     scan_wrap;

  always_comb begin
    ev_wo  = OFFW'(ev_lw_r) << BWL;
    ev_lim = ev_range_r ? lim_r[1] : lim_r[0];
    ev_rem = (ev_lim > LIMW'(ev_wo)) ? (ev_lim - LIMW'(ev_wo)) : '0;
    // page zero is never handed out
    ev_zx  = (ev_range_r ? zero_r[1] : zero_r[0]) && (ev_lw_r == '0);
    for (int j = 0; j < BITS_PER_WORD; j++) begin
      ev_free[j] = (LIMW'(j) < ev_rem) && !((j == 0) && ev_zx) &&
                   !mem_q[BITS_PER_WORD-1-j];
    end
    ev_pick = '0;
    for (int j = BITS_PER_WORD - 1; j >= 0; j--) begin
      if (ev_free[j]) begin
        ev_pick = BWL'(j);
      end
    end
    ev_hit    = ev_v_r && !hit_r && (ev_free != '0);
    scan_wrap = (scan_lw_r == LWW'(WPR - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_done_r <= 1'b1;
      ev_v_r      <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      ev_v_r <= ctrl.scan_rd;
      if (ctrl.scan_init) begin
        scan_done_r <= 1'b0;
        hit_r       <= 1'b0;
      end else begin
        if (ctrl.scan_rd && scan_wrap && scan_range_r) begin
          scan_done_r <= 1'b1;
        end
        if (ev_hit) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan_init) begin
      scan_range_r <= 1'b0;
      scan_lw_r    <= '0;
    end else if (ctrl.scan_rd) begin
      if (scan_wrap) begin
        scan_range_r <= 1'b1;
        scan_lw_r    <= '0;
      end else begin
        scan_lw_r <= scan_lw_r + LWW'(1);
      end
    end
    if (ctrl.scan_rd) begin
      ev_range_r <= scan_range_r;
      ev_lw_r    <= scan_lw_r;
    end
    if (ev_hit) begin
      hit_range_r <= ev_range_r;
      hit_lw_r    <= ev_lw_r;
      hit_j_r     <= ev_pick;
      hit_word_r  <= mem_q;
    end
  end

  // allocated page address
  logic [BWL-1:0]    hit_pos;
  logic [OFFW-1:0]   alloc_off;
  logic [MW-1:0]     alloc_pn;
  logic [ADDR_W-1:0] alloc_addr;

  always_comb begin
    hit_pos    = ~hit_j_r;
    alloc_off  = (OFFW'(hit_lw_r) << BWL) | OFFW'(hit_j_r);
    alloc_pn   = MW'(hit_range_r ? base_r[1] : base_r[0]) + MW'(alloc_off);
    alloc_addr = ADDR_W'(alloc_pn << PBL);
  end

  // memory port muxing
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_idx_r;
    mem_wd = '0;
    if (ctrl.clear_wr) begin
      mem_we = 1'b1;
    end else if (ctrl.single_upd && su_write) begin
      mem_we = 1'b1;
      mem_wa = d_widx_r;
      mem_wd = su_word;
    end else if (ctrl.alloc_wr) begin
      mem_we = 1'b1;
      mem_wa = waddr(hit_range_r, hit_lw_r);
      mem_wd = hit_word_r | (ONE_W << hit_pos);
    end
    mem_re = ctrl.single_rd || ctrl.scan_rd;
    mem_ra = ctrl.single_rd ? dec_widx : waddr(scan_range_r, scan_lw_r);
  end

  // output register
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r;
  status_t             out_status_r;
  logic                out_used_r;
  logic                out_load;

  assign out_load = ctrl.single_upd || ctrl.alloc_wr || ctrl.alloc_fail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.single_upd) begin
      out_addr_r   <= '0;
      out_status_r <= su_status;
      out_used_r   <= su_used_out;
    end else if (ctrl.alloc_wr) begin
      out_addr_r   <= alloc_addr;
      out_status_r <= ST_OK;
      out_used_r   <= 1'b0;
    end else if (ctrl.alloc_fail) begin
      out_addr_r   <= '0;
      out_status_r <= ST_NO_FREE;
      out_used_r   <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;
  assign out_page_used      = out_used_r;

  always_comb begin
    stat.clear_last   = (clr_idx_r == AW'(DEPTH - 1));
    stat.req_alloc    = (cmd_t'(in_command) == CMD_ALLOC);
    stat.hit          = hit_r;
    stat.scan_issued  = scan_done_r;
    stat.eval_pending = ev_v_r;
    stat.out_free     = !out_valid_r || !out_stall;
  end

endmodule
`default_nettype wire

// File: rtl/bitmap_page_allocator.sv
`default_nettype none
// bitmap page allocator: one used bit per page for two configured page ranges
// request channel: in_valid / in_stall with in_command and in_page_address;
//   a request is taken at a clock edge with in_valid high and in_stall low
// result channel: out_valid / out_stall, one result per request, held in an
//   output register so a new request is taken while the last result waits
// config channel: cfg_valid / cfg_ready (always ready), write only while idle
// free, mark used, query: the request is captured, its bitmap word is read
//   through the single read port of the bitmap ram, then the word is updated
//   (free and mark only) and the result is loaded into the output register
// allocate: the scan reads the bitmap words in order, range zero words first,
//   until a word with a free page is found, then writes that word back with
//   the page marked used; with no free page every one of the 2*WPR words is
//   read and the result is ST_NO_FREE; the scan reads one word a cycle and
//   evaluates the word read in the previous cycle
// reset: registers clear and a clearing pass writes zero to each of the 2*WPR
//   bitmap words (256 at the default sizes), with in_stall high; config
//   writes are taken during the pass
// receiver stall: the result waits in the output register; a request that
//   finishes while it still waits holds in its last step until it drains
module bitmap_page_allocator #(
  parameter int PAGE_BYTES      = 4096,
  parameter int BITS_PER_WORD   = 32,
  parameter int PAGES_PER_RANGE = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bpa_pkg::CMD_W-1:0]      in_command,
  input  logic [bpa_pkg::ADDR_W-1:0]     in_page_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bpa_pkg::ADDR_W-1:0]     out_result_address,
  output logic [bpa_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_page_used,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpa_pkg::BASE_W-1:0]     cfg_data
);
  import bpa_pkg::*;

  // command and status between sequencer and datapath
  ctrl_t ctrl;
  stat_t stat;

  // sequencer: clearing pass, request dispatch, scan control
  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // datapath: config registers, bitmap ram, decode, scan, output register
  bpa_datapath #(
    .PAGE_BYTES      (PAGE_BYTES),
    .BITS_PER_WORD   (BITS_PER_WORD),
    .PAGES_PER_RANGE (PAGES_PER_RANGE)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_command),
    .in_page_address    (in_page_address),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_result_address (out_result_address),
    .out_status         (out_status),
    .out_page_used      (out_page_used),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .ctrl               (ctrl),
    .stat               (stat)
  );

endmodule
`default_nettype wire

// File: rtl/bpa_checker.sv
`default_nettype none
module bpa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bpa_pkg::ADDR_W-1:0]     out_result_address,
  input logic [bpa_pkg::STATUS_W-1:0]   out_status,
  input logic                           out_page_used
);
  import bpa_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_address) &&
    $stable(out_status) && $stable(out_page_used))
    else $error("stalled result changed");

  // no result pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // only a successful allocate carries an address
  a_addr_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_result_address == '0))
    else $error("address with error status");

  // error results carry no used bit
  a_used_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_NO_FREE) || (out_status == ST_NOT_IN_RANGE) ||
    (out_status == ST_MISALIGNED) || (out_status == ST_ALREADY_FREE)) |-> !out_page_used)
    else $error("used bit with error status");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
`default_nettype wire
